[rtl/alu8bcd_pkg.sv]
// Package: operation codes, field widths and the result record of the 8-bit ALU.
package alu8bcd_pkg;

	localparam int OP_W = 5;

	localparam logic [OP_W-1:0] OP_ADC = 5'd0;
	localparam logic [OP_W-1:0] OP_AND = 5'd1;
	localparam logic [OP_W-1:0] OP_ASL = 5'd2;
	localparam logic [OP_W-1:0] OP_BIT = 5'd3;
	localparam logic [OP_W-1:0] OP_CMP = 5'd4;
	localparam logic [OP_W-1:0] OP_CPX = 5'd5;
	localparam logic [OP_W-1:0] OP_CPY = 5'd6;
	localparam logic [OP_W-1:0] OP_DEC = 5'd7;
	localparam logic [OP_W-1:0] OP_EOR = 5'd8;
	localparam logic [OP_W-1:0] OP_INC = 5'd9;
	localparam logic [OP_W-1:0] OP_LD  = 5'd10;
	localparam logic [OP_W-1:0] OP_LSR = 5'd11;
	localparam logic [OP_W-1:0] OP_ORA = 5'd12;
	localparam logic [OP_W-1:0] OP_ROL = 5'd13;
	localparam logic [OP_W-1:0] OP_ROR = 5'd14;
	localparam logic [OP_W-1:0] OP_SBC = 5'd15;
	localparam logic [OP_W-1:0] OP_TRB = 5'd16;
	localparam logic [OP_W-1:0] OP_TSB = 5'd17;

	typedef struct packed {
		logic [7:0] result;
		logic       carry;
		logic       overflow;
		logic       zero;
		logic       negative;
		logic       extra;
	} alu_res_t;

endpackage

[rtl/eight_bit_alu_with_bcd_core.sv]
// Top level: registered 8-bit ALU with decimal-mode add and subtract.
// The block takes one beat per clock while in_stall is low and returns one result
// beat for each, in order. Inside, a beat is captured in the input register, the
// operation is evaluated in one pass of logic, and the result register holds it
// until the output side takes it. With the output not stalled the sustained rate
// is one beat per cycle; while the result register is stalled, one further beat
// is taken into the input register before in_stall rises.
module eight_bit_alu_with_bcd_core
	import alu8bcd_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  logic [OP_W-1:0] op,
	input  logic [7:0]      operand,
	input  logic [7:0]      acc_value,
	input  logic [7:0]      x_value,
	input  logic [7:0]      y_value,
	input  logic            carry_in,
	input  logic            overflow_in,
	input  logic            decimal_mode,
	output logic            out_valid,
	input  logic            out_stall,
	output logic [7:0]      result,
	output logic            carry_out,
	output logic            overflow_out,
	output logic            zero_out,
	output logic            negative_out,
	output logic            extra_cycle
);

	logic            valid_s1, valid_s2;
	logic [OP_W-1:0] op_s1;
	logic [7:0]      m_s1, a_s1, x_s1, y_s1;
	logic            c_s1, v_s1, d_s1;
	alu_res_t        res_s2;
	alu_res_t        res;
	logic            s1_free, s2_free;

	// Handshake: a stage is free when empty or when it drains this cycle
	assign s2_free  = !valid_s2 || !out_stall;
	assign s1_free  = !valid_s1 || s2_free;
	assign in_stall = !s1_free;

	// Capture the input beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_free) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_free && in_valid) begin
			op_s1 <= op;
			m_s1  <= operand;
			a_s1  <= acc_value;
			x_s1  <= x_value;
			y_s1  <= y_value;
			c_s1  <= carry_in;
			v_s1  <= overflow_in;
			d_s1  <= decimal_mode;
		end
	end

	// Adder path shared by adc and sbc; sbc adds the inverted operand
	logic       is_sub;
	logic [7:0] b_add;
	logic [8:0] bin_sum;
	logic       bin_v;
	logic [4:0] lo_raw;
	logic [5:0] lo_add;
	logic [3:0] lo_nib;
	logic       mid;
	logic [8:0] hi_raw;
	logic [9:0] hi_adj;

	always_comb begin
		is_sub  = (op_s1 == OP_SBC);
		b_add   = is_sub ? ~m_s1 : m_s1;
		bin_sum = {1'b0, a_s1} + {1'b0, b_add} + {8'd0, c_s1};
		bin_v   = ~(a_s1[7] ^ b_add[7]) & (a_s1[7] ^ bin_sum[7]);

		// Low digit with decimal correction
		lo_raw = {1'b0, a_s1[3:0]} + {1'b0, b_add[3:0]} + {4'd0, c_s1};
		lo_add = (lo_raw > 5'd9) ? ({1'b0, lo_raw} + 6'd6) : {1'b0, lo_raw};
		if (is_sub) begin
			mid    = (lo_raw > 5'd15);
			lo_nib = (lo_raw <= 5'd15) ? (lo_raw[3:0] - 4'd6) : lo_raw[3:0];
		end else begin
			mid    = (lo_add > 6'd15);
			lo_nib = lo_add[3:0];
		end

		// High digit; wraps as two's complement so bit 8 carries the flag
		hi_raw = {1'b0, a_s1[7:4], 4'd0} + {1'b0, b_add[7:4], 4'd0}
			+ {4'd0, mid, 4'd0} + {5'd0, lo_nib};
		if (is_sub) begin
			hi_adj = (hi_raw <= 9'h0ff) ? ({1'b0, hi_raw} - 10'h060) : {1'b0, hi_raw};
		end else begin
			hi_adj = (hi_raw > 9'h09f) ? ({1'b0, hi_raw} + 10'h060) : {1'b0, hi_raw};
		end
	end

	// Compare path
	logic [7:0] cmp_reg;
	logic [8:0] cmp_diff;

	always_comb begin
		if (op_s1 == OP_CMP) begin
			cmp_reg = a_s1;
		end else if (op_s1 == OP_CPX) begin
			cmp_reg = x_s1;
		end else begin
			cmp_reg = y_s1;
		end
		cmp_diff = {1'b0, cmp_reg} - {1'b0, m_s1};
	end

	// Select the operation and form the flags
	always_comb begin
		res.result   = a_s1;
		res.carry    = c_s1;
		res.overflow = v_s1;
		res.extra    = 1'b0;
		res.zero     = 1'b0;
		res.negative = 1'b0;
		unique case (op_s1)
			OP_ADC, OP_SBC: begin
				if (d_s1) begin
					res.result = hi_adj[7:0];
					res.carry  = hi_adj[8];
					res.extra  = 1'b1;
				end else begin
					res.result   = bin_sum[7:0];
					res.carry    = bin_sum[8];
					res.overflow = bin_v;
				end
			end
			OP_AND: res.result = a_s1 & m_s1;
			OP_EOR: res.result = a_s1 ^ m_s1;
			OP_ORA: res.result = a_s1 | m_s1;
			OP_ASL: begin
				res.result = {m_s1[6:0], 1'b0};
				res.carry  = m_s1[7];
			end
			OP_LSR: begin
				res.result = {1'b0, m_s1[7:1]};
				res.carry  = m_s1[0];
			end
			OP_ROL: begin
				res.result = {m_s1[6:0], c_s1};
				res.carry  = m_s1[7];
			end
			OP_ROR: begin
				res.result = {c_s1, m_s1[7:1]};
				res.carry  = m_s1[0];
			end
			OP_DEC: res.result = m_s1 - 8'd1;
			OP_INC: res.result = m_s1 + 8'd1;
			OP_LD:  res.result = m_s1;
			OP_CMP, OP_CPX, OP_CPY: begin
				res.result = cmp_reg;
				res.carry  = ~cmp_diff[8];
			end
			OP_BIT: begin
				res.result   = a_s1;
				res.overflow = m_s1[6];
			end
			OP_TRB: begin
				res.result   = ~a_s1 & m_s1;
				res.overflow = m_s1[6];
			end
			OP_TSB: begin
				res.result   = a_s1 | m_s1;
				res.overflow = m_s1[6];
			end
			default: res.result = a_s1;
		endcase

		// Z and N: compares look at the difference, bit tests at A AND M and M
		if (op_s1 == OP_CMP || op_s1 == OP_CPX || op_s1 == OP_CPY) begin
			res.zero     = (cmp_diff[7:0] == 8'd0);
			res.negative = cmp_diff[7];
		end else if (op_s1 == OP_BIT || op_s1 == OP_TRB || op_s1 == OP_TSB) begin
			res.zero     = ((a_s1 & m_s1) == 8'd0);
			res.negative = m_s1[7];
		end else begin
			res.zero     = (res.result == 8'd0);
			res.negative = res.result[7];
		end
	end

	// Advance into the result register, hold while stalled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_free) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_free && valid_s1) begin
			res_s2 <= res;
		end
	end

	assign out_valid    = valid_s2;
	assign result       = res_s2.result;
	assign carry_out    = res_s2.carry;
	assign overflow_out = res_s2.overflow;
	assign zero_out     = res_s2.zero;
	assign negative_out = res_s2.negative;
	assign extra_cycle  = res_s2.extra;

endmodule

[rtl/alu8bcd_checker.sv]
// Checker: port-level assertions for the 8-bit ALU, bound to the top level.
module alu8bcd_checker (
	input logic            clk,
	input logic            arst_n,
	input logic            in_valid,
	input logic            in_stall,
	input logic            out_valid,
	input logic            out_stall,
	input logic [7:0]      result,
	input logic            carry_out,
	input logic            overflow_out,
	input logic            zero_out,
	input logic            negative_out,
	input logic            extra_cycle
);

	// A stalled result beat stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result beat dropped while stalled");

	// A stalled result beat keeps its payload
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(result) && $stable(carry_out)
			&& $stable(overflow_out) && $stable(zero_out)
			&& $stable(negative_out) && $stable(extra_cycle))
		else $error("result payload changed while stalled");

	// With no result waiting the input side must not stall
	a_no_idle_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("input stalled with empty result register");

	// An accepted beat passes the input and result registers and is then on the output, or a beat ahead of it is
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |-> ##2 out_valid)
		else $error("accepted beat did not reach the result register");

endmodule

bind eight_bit_alu_with_bcd_core alu8bcd_checker u_alu8bcd_checker (.*);

[sim/tb.sv]
// Testbench for the registered 8-bit ALU with decimal-mode add and subtract.
`timescale 1ns / 100ps

module tb;
	import alu8bcd_pkg::*;

	// Operation codes the block does not define: it passes A through
	localparam logic [OP_W-1:0] OP_SPARE_LO = 5'd18;
	localparam logic [OP_W-1:0] OP_SPARE_HI = 5'd31;

	typedef struct packed {
		logic [OP_W-1:0] op_code;
		logic [7:0]      operand;
		logic [7:0]      acc;
		logic [7:0]      x;
		logic [7:0]      y;
		logic            carry;
		logic            ovf;
		logic            dec;
	} alu_beat_t;

	// Predicted flag and result words, checked in order of arrival
	class alu_scoreboard;
		alu_res_t due_results[$];
		int       mismatches;

		task report(string what, int got_v, int exp_v);
			$display("tb: mismatch on %s: got %0h, expected %0h", what, got_v, exp_v);
			mismatches++;
		endtask

		function alu_res_t predict(alu_beat_t b);
			alu_res_t   r;
			logic [7:0] addend;
			logic [7:0] reg_v;
			logic [8:0] diff;
			int         lo;
			int         hi;
			int         sum;
			bit         sub;
			bit         own_zn;
			r.result   = b.acc;
			r.carry    = b.carry;
			r.overflow = b.ovf;
			r.extra    = 1'b0;
			own_zn     = 1'b0;
			case (b.op_code)
			OP_ADC, OP_SBC: begin
				sub    = (b.op_code == OP_SBC);
				addend = sub ? ~b.operand : b.operand;
				if (!b.dec) begin
					sum = b.acc + addend + b.carry;
					r.overflow = (b.acc[7] == addend[7]) && (b.acc[7] != sum[7]);
				end else begin
					// BCD fix-up, low digit then high digit, in 32-bit two's complement
					lo = b.acc[3:0] + addend[3:0] + b.carry;
					if (sub) begin
						if (lo <= 15)
							lo = lo - 6;
					end else if (lo > 9) begin
						lo = lo + 6;
					end
					hi = b.acc[7:4] * 16 + addend[7:4] * 16 + ((lo > 15) ? 16 : 0) + (lo & 15);
					if (sub) begin
						if (hi <= 255)
							hi = hi - 96;
					end else if (hi > 159) begin
						hi = hi + 96;
					end
					sum     = hi;
					r.extra = 1'b1;
				end
				r.result = sum[7:0];
				r.carry  = sum[8];
			end
			OP_AND: r.result = b.acc & b.operand;
			OP_EOR: r.result = b.acc ^ b.operand;
			OP_ORA: r.result = b.acc | b.operand;
			OP_ASL: begin
				r.carry  = b.operand[7];
				r.result = {b.operand[6:0], 1'b0};
			end
			OP_LSR: begin
				r.carry  = b.operand[0];
				r.result = {1'b0, b.operand[7:1]};
			end
			OP_ROL: begin
				r.carry  = b.operand[7];
				r.result = {b.operand[6:0], b.carry};
			end
			OP_ROR: begin
				r.carry  = b.operand[0];
				r.result = {b.carry, b.operand[7:1]};
			end
			OP_DEC: r.result = b.operand - 8'd1;
			OP_INC: r.result = b.operand + 8'd1;
			OP_LD:  r.result = b.operand;
			OP_CMP, OP_CPX, OP_CPY: begin
				// Compare: the register comes back, flags follow the 9-bit difference
				reg_v = (b.op_code == OP_CMP) ? b.acc : ((b.op_code == OP_CPX) ? b.x : b.y);
				diff  = {1'b0, reg_v} - {1'b0, b.operand};
				r.result   = reg_v;
				r.carry    = ~diff[8];
				r.zero     = (diff[7:0] == 8'd0);
				r.negative = diff[7];
				own_zn     = 1'b1;
			end
			OP_BIT, OP_TRB, OP_TSB: begin
				// Bit tests: Z from A AND operand, V and N from the operand
				if (b.op_code == OP_BIT)
					r.result = b.acc;
				else if (b.op_code == OP_TRB)
					r.result = ~b.acc & b.operand;
				else
					r.result = b.acc | b.operand;
				r.overflow = b.operand[6];
				r.zero     = ((b.acc & b.operand) == 8'd0);
				r.negative = b.operand[7];
				own_zn     = 1'b1;
			end
			default: r.result = b.acc;
			endcase
			if (!own_zn) begin
				r.zero     = (r.result == 8'd0);
				r.negative = r.result[7];
			end
			return r;
		endfunction

		function void note_beat(alu_beat_t b);
			due_results.push_back(predict(b));
		endfunction

		task check_beat(alu_res_t got);
			alu_res_t want;
			if (due_results.size() == 0) begin
				report("unexpected result", got.result, 0);
			end else begin
				want = due_results.pop_front();
				if (got.result !== want.result)
					report("result", got.result, want.result);
				if (got.carry !== want.carry)
					report("carry_out", got.carry, want.carry);
				if (got.overflow !== want.overflow)
					report("overflow_out", got.overflow, want.overflow);
				if (got.zero !== want.zero)
					report("zero_out", got.zero, want.zero);
				if (got.negative !== want.negative)
					report("negative_out", got.negative, want.negative);
				if (got.extra !== want.extra)
					report("extra_cycle", got.extra, want.extra);
			end
		endtask
	endclass

	logic            clk;
	logic            arst_n;
	logic            in_valid;
	logic            in_stall;
	logic [OP_W-1:0] op;
	logic [7:0]      operand;
	logic [7:0]      acc_value;
	logic [7:0]      x_value;
	logic [7:0]      y_value;
	logic            carry_in;
	logic            overflow_in;
	logic            decimal_mode;
	logic            out_valid;
	logic            out_stall;
	logic [7:0]      result;
	logic            carry_out;
	logic            overflow_out;
	logic            zero_out;
	logic            negative_out;
	logic            extra_cycle;

	alu_scoreboard sb;
	bit            calm;
	int            n_results;
	int            stall_left;
	int            hold;

	eight_bit_alu_with_bcd_core i_dut (.*);

	// Free-running clock
	always #5 clk = ~clk;

	// Pause length: mostly none, some short, a few long; none in calm stretches
	function automatic int pick_pause();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 50);
	endfunction

	function automatic alu_beat_t mk(logic [OP_W-1:0] o, logic [7:0] m, logic [7:0] a,
			logic [7:0] xv, logic [7:0] yv, logic c, logic v, logic d);
		return '{o, m, a, xv, yv, c, v, d};
	endfunction

	// Offer one beat, hold it until taken, then idle for a random gap
	task automatic send_beat(alu_beat_t b);
		int gap;
		op           <= b.op_code;
		operand      <= b.operand;
		acc_value    <= b.acc;
		x_value      <= b.x;
		y_value      <= b.y;
		carry_in     <= b.carry;
		overflow_in  <= b.ovf;
		decimal_mode <= b.dec;
		in_valid     <= 1'b1;
		do
			@(posedge clk);
		while (in_stall);
		sb.note_beat(b);
		gap = pick_pause();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Take result beats, check them, stall the output side at random
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				sb.check_beat(alu_res_t'{result, carry_out, overflow_out, zero_out,
					negative_out, extra_cycle});
				n_results++;
				// Long hold-off so the block fills and stalls its input
				if (n_results == 300 || n_results == 1200)
					stall_left = 80;
			end
			if (stall_left > 0) begin
				out_stall <= 1'b1;
				stall_left--;
			end else begin
				hold = pick_pause();
				out_stall <= (hold > 0);
				stall_left = (hold > 0) ? hold - 1 : 0;
			end
		end
	end

	// Stimulus: directed corner cases, then random beats
	initial begin
		alu_beat_t b;
		sb           = new();
		clk          = 1'b0;
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		out_stall    = 1'b0;
		op           = OP_LD;
		operand      = 8'd0;
		acc_value    = 8'd0;
		x_value      = 8'd0;
		y_value      = 8'd0;
		carry_in     = 1'b0;
		overflow_in  = 1'b0;
		decimal_mode = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Binary and decimal add and subtract edges, including bad BCD digits
		send_beat(mk(OP_ADC, 8'h01, 8'h7f, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0));
		send_beat(mk(OP_ADC, 8'hff, 8'hff, 8'hff, 8'hff, 1'b1, 1'b1, 1'b0));
		send_beat(mk(OP_ADC, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b1, 1'b1));
		send_beat(mk(OP_ADC, 8'h01, 8'h99, 8'h00, 8'h00, 1'b0, 1'b0, 1'b1));
		send_beat(mk(OP_ADC, 8'hff, 8'hff, 8'h00, 8'h00, 1'b1, 1'b1, 1'b1));
		send_beat(mk(OP_SBC, 8'h01, 8'h00, 8'h00, 8'h00, 1'b1, 1'b0, 1'b0));
		send_beat(mk(OP_SBC, 8'h80, 8'h7f, 8'h00, 8'h00, 1'b1, 1'b0, 1'b0));
		send_beat(mk(OP_SBC, 8'h0f, 8'h00, 8'h00, 8'h00, 1'b0, 1'b1, 1'b1));
		send_beat(mk(OP_SBC, 8'hff, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 1'b1));
		send_beat(mk(OP_SBC, 8'h12, 8'h46, 8'h00, 8'h00, 1'b1, 1'b0, 1'b1));
		// Logic, shifts, rotates, steps and loads at the byte extremes
		send_beat(mk(OP_AND, 8'hff, 8'h00, 8'h00, 8'h00, 1'b1, 1'b1, 1'b0));
		send_beat(mk(OP_ASL, 8'h80, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 1'b1));
		send_beat(mk(OP_EOR, 8'hff, 8'hff, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0));
		send_beat(mk(OP_ORA, 8'h00, 8'h00, 8'hff, 8'hff, 1'b1, 1'b0, 1'b0));
		send_beat(mk(OP_LSR, 8'h01, 8'hff, 8'h00, 8'h00, 1'b0, 1'b1, 1'b0));
		send_beat(mk(OP_ROL, 8'h80, 8'h00, 8'h00, 8'h00, 1'b1, 1'b0, 1'b0));
		send_beat(mk(OP_ROR, 8'h01, 8'h00, 8'h00, 8'h00, 1'b1, 1'b0, 1'b0));
		send_beat(mk(OP_DEC, 8'h00, 8'h55, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0));
		send_beat(mk(OP_INC, 8'hff, 8'h00, 8'h00, 8'h00, 1'b1, 1'b1, 1'b1));
		send_beat(mk(OP_LD, 8'h00, 8'hff, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0));
		// Compares: equal, register above, register below
		send_beat(mk(OP_CMP, 8'h40, 8'h40, 8'h00, 8'h00, 1'b0, 1'b1, 1'b0));
		send_beat(mk(OP_CPX, 8'h10, 8'h00, 8'hff, 8'h00, 1'b0, 1'b0, 1'b0));
		send_beat(mk(OP_CPY, 8'hff, 8'h00, 8'h00, 8'h00, 1'b1, 1'b0, 1'b0));
		// Bit tests with Z from the mask, V and N from the operand
		send_beat(mk(OP_BIT, 8'hc0, 8'h3f, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0));
		send_beat(mk(OP_TRB, 8'hff, 8'h0f, 8'h00, 8'h00, 1'b0, 1'b1, 1'b0));
		send_beat(mk(OP_TSB, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 1'b1, 1'b0));
		// Undefined codes pass A through
		send_beat(mk(OP_SPARE_LO, 8'hff, 8'h00, 8'h00, 8'h00, 1'b1, 1'b1, 1'b1));
		send_beat(mk(OP_SPARE_HI, 8'h00, 8'h80, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0));

		// Random beats, with calm stretches free of random gaps and random stalls
		for (int i = 0; i < 1625; i++) begin
			calm = ((i / 150) % 4) == 3;
			if ($urandom_range(0, 9) == 0)
				b.op_code = OP_W'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
			else
				b.op_code = OP_W'($urandom_range(OP_ADC, OP_TSB));
			b.operand = 8'($urandom);
			b.acc     = 8'($urandom);
			b.x       = 8'($urandom);
			b.y       = 8'($urandom);
			b.carry   = 1'($urandom);
			b.ovf     = 1'($urandom);
			b.dec     = 1'($urandom);
			// Weight decimal arithmetic towards well-formed BCD digits
			if ((b.op_code == OP_ADC || b.op_code == OP_SBC) && $urandom_range(0, 3) != 0) begin
				b.dec = 1'b1;
				if ($urandom_range(0, 2) != 0) begin
					b.operand = {4'($urandom_range(0, 9)), 4'($urandom_range(0, 9))};
					b.acc     = {4'($urandom_range(0, 9)), 4'($urandom_range(0, 9))};
				end
			end
			// Now and then an extreme operand
			case ($urandom_range(0, 15))
			0: b.operand = 8'h00;
			1: b.operand = 8'hff;
			2: b.operand = 8'h80;
			3: b.operand = 8'h7f;
			default: ;
			endcase
			send_beat(b);
		end
		calm = 1'b0;
		in_valid <= 1'b0;

		// Drain, then allow for stray beats
		while (sb.due_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (sb.mismatches == 0)
			$display("tb: PASS");
		else
			$display("tb: FAIL");
		$finish;
	end

	// Watchdog
	initial begin
		#(20ms);
		$display("tb: FAIL");
		$finish;
	end

endmodule
